>>> src/rdd_pkg.sv
// ----------------------------------------------------------------------------
// rdd_pkg: shared definitions for the room dispatcher
// Field widths, saturation limits, reset values and the job and result words.
// ----------------------------------------------------------------------------
package rdd_pkg;

  localparam int unsigned ROOMS_DEFAULT = 16;
  localparam int unsigned TIME_W        = 48;
  localparam int unsigned COUNT_W       = 32;
  localparam int unsigned STAMP_W       = 32;
  localparam int unsigned ROOM_W        = 4;
  localparam int unsigned CFG_W         = 5;

  localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(16);
  localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic [STAMP_W-1:0] start_time;
    logic [STAMP_W-1:0] due_time;
    logic               first;
  } job_t;

  typedef struct packed {
    logic [ROOM_W-1:0]  room;
    logic [TIME_W-1:0]  actual_end;
    logic               delayed;
    logic [ROOM_W-1:0]  busiest_room;
    logic [COUNT_W-1:0] busiest_count;
  } result_t;

endpackage

>>> src/rdd_if.sv
// ----------------------------------------------------------------------------
// rdd_if: valid/ready channels of the room dispatcher
// One interface for the job words and one for the result words.
// ----------------------------------------------------------------------------
interface rdd_job_if;
  logic          valid;
  logic          ready;
  rdd_pkg::job_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rdd_result_if;
  logic             valid;
  logic             ready;
  rdd_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/room_dispatch_with_delay_core.sv
// ----------------------------------------------------------------------------
// room_dispatch_with_delay_core: lowest-free room dispatcher with delay
// Places each job in the lowest free room, or delays it into the room that
// frees earliest, and tracks per-room free times, job counts and the busiest.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake        Word
//   job_i     in         valid / ready    start_time, due_time, first
//   result_o  out        valid / ready    room, actual_end, delayed,
//                                         busiest_room, busiest_count
//   cfg       in         cfg_we_i         rooms_in_use (5 bits)
//
// A job passes from acceptance into the input register, then through the
// selection tree, the end-time adder and the count update into the result
// register. The room state is written on the same edge, so a new job can be
// accepted every cycle unless the result side stalls. The critical path is
// the 48-bit free-time compares and the log2(ROOMS)-level minimum tree
// followed by the saturating end-time adder. Reset clears all room state and
// sets the room count to 16; a job with first set clears it again before it
// is handled. A stall at the result side holds the result register and then
// the input register; ready propagates back combinationally, so no word is lost.
//
module room_dispatch_with_delay_core #(
  parameter int unsigned ROOMS = rdd_pkg::ROOMS_DEFAULT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [rdd_pkg::CFG_W-1:0] cfg_wdata_i,
  rdd_job_if.sink                   job_i,
  rdd_result_if.source              result_o
);

  // Room index width, and a width that holds both the register value and
  // ROOMS itself so the active-room count can be clamped.
  localparam int unsigned IW = (ROOMS > 1) ? $clog2(ROOMS) : 1;
  localparam int unsigned NW = (IW + 1 > rdd_pkg::CFG_W) ? IW + 1 : rdd_pkg::CFG_W;

  localparam int unsigned TW = rdd_pkg::TIME_W;
  localparam int unsigned CW = rdd_pkg::COUNT_W;
  localparam int unsigned SW = rdd_pkg::STAMP_W;
  localparam int unsigned RW = rdd_pkg::ROOM_W;

  // Configuration register.
  logic [rdd_pkg::CFG_W-1:0] cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= rdd_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // Number of rooms taking part: zero acts as one, anything above ROOMS as ROOMS.
  logic [NW-1:0]    cfg_ext;
  logic [NW-1:0]    n_active;
  logic [ROOMS-1:0] active;

  assign cfg_ext = NW'(cfg_q);

  always_comb begin
    if (cfg_ext == '0) begin
      n_active = NW'(1);
    end else if (cfg_ext > NW'(ROOMS)) begin
      n_active = NW'(ROOMS);
    end else begin
      n_active = cfg_ext;
    end
  end

  for (genvar i = 0; i < ROOMS; i++) begin : g_active
    assign active[i] = NW'(i) < n_active;
  end

  // Input register and pipeline control. The job is processed when it sits
  // in the input register and the result register is empty or being drained.
  logic          in_valid_q, in_valid_d;
  rdd_pkg::job_t in_q;
  logic          out_valid_q, out_valid_d;
  logic          advance;

  assign advance     = in_valid_q && (!out_valid_q || result_o.ready);
  assign job_i.ready = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (job_i.valid && job_i.ready) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_i.valid && job_i.ready) begin
      in_q <= job_i.data;
    end
  end

  // Room state. A job flagged first sees all of it as cleared.
  logic [TW-1:0] free_q [ROOMS];
  logic [CW-1:0] jobs_q [ROOMS];
  logic [IW-1:0] best_room_q;
  logic [CW-1:0] best_count_q;

  logic [TW-1:0] free_eff [ROOMS];
  logic [CW-1:0] jobs_eff [ROOMS];
  logic [IW-1:0] best_room_eff;
  logic [CW-1:0] best_count_eff;

  for (genvar i = 0; i < ROOMS; i++) begin : g_eff
    assign free_eff[i] = in_q.first ? '0 : free_q[i];
    assign jobs_eff[i] = in_q.first ? '0 : jobs_q[i];
  end
  assign best_room_eff  = in_q.first ? '0 : best_room_q;
  assign best_count_eff = in_q.first ? '0 : best_count_q;

  // Selection of the lowest free room and of the earliest-freeing room.
  logic          found;
  logic [IW-1:0] free_idx;
  logic [IW-1:0] early_idx;
  logic [TW-1:0] early_time;

  rdd_select #(
    .ROOMS (ROOMS),
    .IW    (IW)
  ) u_select (
    .free_at_i    (free_eff),
    .active_i     (active),
    .start_i      (TW'(in_q.start_time)),
    .found_o      (found),
    .free_idx_o   (free_idx),
    .early_idx_o  (early_idx),
    .early_time_o (early_time)
  );

  // Duration is zero when the end is not past the start. A job that finds a
  // free room ends at its start plus that duration; a delayed job runs from the time its
  // room frees, and that sum saturates at the largest time.
  logic [SW-1:0]   dur;
  logic [TW:0]     late_sum;
  logic [TW-1:0]   fin;
  logic [IW-1:0]   pick;
  logic [CW-1:0]   cnt_old;
  logic [CW-1:0]   cnt;
  logic            take_best;
  logic [IW-1:0]   best_room_new;
  logic [CW-1:0]   best_count_new;

  assign dur      = (in_q.due_time > in_q.start_time) ? in_q.due_time - in_q.start_time : '0;
  assign late_sum = {1'b0, early_time} + (TW + 1)'(dur);
  assign pick     = found ? free_idx : early_idx;

  always_comb begin
    if (found) begin
      fin = TW'(in_q.start_time) + TW'(dur);
    end else if (late_sum[TW]) begin
      fin = rdd_pkg::TIME_MAX;
    end else begin
      fin = late_sum[TW-1:0];
    end
  end

  assign cnt_old = jobs_eff[pick];
  assign cnt     = (cnt_old == rdd_pkg::COUNT_MAX) ? cnt_old : cnt_old + CW'(1);

  // The busiest room moves on a larger count, or on an equal count held by a
  // lower-numbered room.
  assign take_best      = (cnt > best_count_eff) ||
                          ((cnt == best_count_eff) && (pick < best_room_eff));
  assign best_room_new  = take_best ? pick : best_room_eff;
  assign best_count_new = take_best ? cnt : best_count_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ROOMS; i++) begin
        free_q[i] <= '0;
        jobs_q[i] <= '0;
      end
      best_room_q  <= '0;
      best_count_q <= '0;
    end else if (advance) begin
      for (int i = 0; i < ROOMS; i++) begin
        if (IW'(i) == pick) begin
          free_q[i] <= fin;
          jobs_q[i] <= cnt;
        end else if (in_q.first) begin
          free_q[i] <= '0;
          jobs_q[i] <= '0;
        end
      end
      best_room_q  <= best_room_new;
      best_count_q <= best_count_new;
    end
  end

  // Result register. Room numbers go out as four bits.
  logic [IW+RW-1:0] pick_ext;
  logic [IW+RW-1:0] best_ext;
  rdd_pkg::result_t out_q;

  assign pick_ext = {{RW{1'b0}}, pick};
  assign best_ext = {{RW{1'b0}}, best_room_new};

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.room          <= pick_ext[RW-1:0];
      out_q.actual_end    <= fin;
      out_q.delayed       <= !found;
      out_q.busiest_room  <= best_ext[RW-1:0];
      out_q.busiest_count <= best_count_new;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

endmodule

>>> src/rdd_select.sv
// ----------------------------------------------------------------------------
// rdd_select: room selection tree
// Finds the lowest active room that is free at the start time, and the active
// room that frees earliest, lower index winning ties, in one binary tree.
// ----------------------------------------------------------------------------
module rdd_select #(
  parameter int unsigned ROOMS = rdd_pkg::ROOMS_DEFAULT,
  parameter int unsigned IW    = 4
) (
  input  logic [rdd_pkg::TIME_W-1:0] free_at_i [ROOMS],
  input  logic [ROOMS-1:0]           active_i,
  input  logic [rdd_pkg::TIME_W-1:0] start_i,
  output logic                       found_o,
  output logic [IW-1:0]              free_idx_o,
  output logic [IW-1:0]              early_idx_o,
  output logic [rdd_pkg::TIME_W-1:0] early_time_o
);

  localparam int unsigned LEVELS = $clog2(ROOMS);
  localparam int unsigned LEAVES = 1 << LEVELS;
  localparam int unsigned NODES  = 2 * LEAVES - 1;

  // Heap layout: node k has children 2k and 2k+1, leaves start at LEAVES.
  logic                       nd_valid [1:NODES];
  logic                       nd_free  [1:NODES];
  logic [IW-1:0]              nd_fidx  [1:NODES];
  logic [IW-1:0]              nd_eidx  [1:NODES];
  logic [rdd_pkg::TIME_W-1:0] nd_time  [1:NODES];

  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < ROOMS) begin : g_room
      assign nd_valid[LEAVES+i] = active_i[i];
      assign nd_free[LEAVES+i]  = active_i[i] && (free_at_i[i] <= start_i);
      assign nd_time[LEAVES+i]  = free_at_i[i];
    end else begin : g_pad
      assign nd_valid[LEAVES+i] = 1'b0;
      assign nd_free[LEAVES+i]  = 1'b0;
      assign nd_time[LEAVES+i]  = '0;
    end
    assign nd_fidx[LEAVES+i] = IW'(i);
    assign nd_eidx[LEAVES+i] = IW'(i);
  end

  for (genvar k = 1; k < LEAVES; k++) begin : g_node
    logic take_left;
    assign take_left = nd_valid[2*k] && (!nd_valid[2*k+1] || (nd_time[2*k] <= nd_time[2*k+1]));
    assign nd_valid[k] = nd_valid[2*k] | nd_valid[2*k+1];
    assign nd_free[k]  = nd_free[2*k] | nd_free[2*k+1];
    assign nd_fidx[k]  = nd_free[2*k] ? nd_fidx[2*k] : nd_fidx[2*k+1];
    assign nd_eidx[k]  = take_left ? nd_eidx[2*k] : nd_eidx[2*k+1];
    assign nd_time[k]  = take_left ? nd_time[2*k] : nd_time[2*k+1];
  end

  // The root sees every active room; room 0 is always active, so it is valid.
  assign found_o      = nd_free[1];
  assign free_idx_o   = nd_fidx[1];
  assign early_idx_o  = nd_eidx[1];
  assign early_time_o = nd_time[1];

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for room_dispatch_with_delay_core
// Drives job words with random valid gaps and result stalls, predicts every
// result word from a cycle-free model of the room table, and compares each
// accepted result field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rdd_pkg::*;

  localparam int ROOM_SLOTS  = 16;
  localparam int CYCLE_LIMIT = 100_000;
  localparam int DRAIN_GAP   = 4;       // two pipeline stages plus margin
  localparam int TAIL_CYCLES = 10;
  localparam int LONG_HOLD   = 64;      // result stall long enough to back up the inputs
  localparam int DELAY_CHAIN = 24;      // delayed full-width jobs stacked on one room

  // Scoreboard: keeps its own copy of the room table and the room count, and
  // turns each accepted job word into the result word the block must return.
  class dispatch_ledger;
    logic [TIME_W-1:0]  free_at   [ROOM_SLOTS];
    logic [COUNT_W-1:0] jobs_held [ROOM_SLOTS];
    logic [ROOM_W-1:0]  lead_room;
    logic [COUNT_W-1:0] lead_count;
    logic [CFG_W-1:0]   room_count;
    result_t            awaited [$];
    int                 errors;

    function new();
      room_count = CFG_RESET;
      errors     = 0;
      clear_rooms();
    endfunction

    function void clear_rooms();
      foreach (free_at[i]) begin
        free_at[i]   = '0;
        jobs_held[i] = '0;
      end
      lead_room  = '0;
      lead_count = '0;
    endfunction

    task flag_mismatch(string what);
      errors++;
      $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    function void log_job(job_t j);
      logic [TIME_W-1:0]  span;
      logic [TIME_W-1:0]  fin;
      logic [COUNT_W-1:0] held;
      int                 n;
      int                 pick;
      int                 early;
      bit                 found;
      result_t            r;
      span = '0;
      if (j.due_time > j.start_time) span = j.due_time - j.start_time;
      n = (room_count == 0) ? 1 : (room_count > ROOM_SLOTS) ? ROOM_SLOTS : int'(room_count);
      if (j.first) clear_rooms();
      found = 1'b0;
      pick  = 0;
      early = 0;
      for (int i = 0; i < n; i++) begin
        if (!found && free_at[i] <= j.start_time) begin
          pick  = i;
          found = 1'b1;
        end
        if (free_at[i] < free_at[early]) early = i;
      end
      if (found) begin
        fin = j.start_time + span;
      end else begin
        // Nothing free: wait for the earliest room, then run the full duration.
        pick = early;
        fin  = free_at[pick];
        fin  = (TIME_MAX - fin < span) ? TIME_MAX : fin + span;
      end
      free_at[pick] = fin;
      held = jobs_held[pick];
      if (held != COUNT_MAX) held++;
      jobs_held[pick] = held;
      if (held > lead_count || (held == lead_count && pick < lead_room)) begin
        lead_count = held;
        lead_room  = pick[ROOM_W-1:0];
      end
      r.room          = pick[ROOM_W-1:0];
      r.actual_end    = fin;
      r.delayed       = !found;
      r.busiest_room  = lead_room;
      r.busiest_count = lead_count;
      awaited.push_back(r);
    endfunction

    task check_assignment(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        flag_mismatch($sformatf("result word with nothing awaited (room %0d, end %0d)",
                                got.room, got.actual_end));
        return;
      end
      want = awaited.pop_front();
      if (got.room !== want.room)
        flag_mismatch($sformatf("room %0d, expected %0d", got.room, want.room));
      if (got.actual_end !== want.actual_end)
        flag_mismatch($sformatf("actual_end %0d, expected %0d",
                                got.actual_end, want.actual_end));
      if (got.delayed !== want.delayed)
        flag_mismatch($sformatf("delayed %0b, expected %0b", got.delayed, want.delayed));
      if (got.busiest_room !== want.busiest_room)
        flag_mismatch($sformatf("busiest_room %0d, expected %0d",
                                got.busiest_room, want.busiest_room));
      if (got.busiest_count !== want.busiest_count)
        flag_mismatch($sformatf("busiest_count %0d, expected %0d",
                                got.busiest_count, want.busiest_count));
    endtask
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  rdd_job_if    job_if ();
  rdd_result_if res_if ();

  dispatch_ledger ledger;

  // Stimulus mode flags. The calm flag turns off all idling for the last part
  // of the run, steady keeps the sender offering words back to back, and
  // hold_request asks the result side for one long stall.
  bit calm;
  bit steady;
  bit hold_request;
  int cycles;

  room_dispatch_with_delay_core #(.ROOMS(ROOM_SLOTS)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .job_i       (job_if),
    .result_o    (res_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watchdog. The limit is several times the slowest legal run: every word
  // paying a full sender gap and a full result stall, plus the long hold and
  // the drains before each room count change.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Both handshakes are sampled at the rising edge, before the block's
  // registers move. A job word is logged before the result word of the same
  // edge is checked, so the FIFO order of expectations always holds.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (job_if.valid && job_if.ready) ledger.log_job(job_if.data);
      if (res_if.valid && res_if.ready) ledger.check_assignment(res_if.data);
    end
  end

  // Result side. Ready moves only at falling edges, in runs: random stall
  // bursts between random open stretches, a single long hold when
  // asked for, and no stalls at all once the run turns calm.
  initial begin : result_side
    int left;
    bit level;
    left  = 0;
    level = 1'b0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (left == 0) begin
        if (hold_request) begin
          hold_request = 1'b0;
          level = 1'b0;
          left  = LONG_HOLD;
        end else if (calm) begin
          level = 1'b1;
          left  = 1;
        end else if ($urandom_range(0, 3) == 0) begin
          level = 1'b0;
          left  = $urandom_range(1, 8);
        end else begin
          level = 1'b1;
          left  = $urandom_range(1, 16);
        end
      end
      res_if.ready <= level;
      left--;
    end
  end

  // Offers one job word and returns at the falling edge after it was taken.
  // Valid stays high on return, so the next word follows without a bubble;
  // callers that stop sending lower it through settle_block.
  task automatic send_job(input logic [STAMP_W-1:0] start_at,
                          input logic [STAMP_W-1:0] end_at,
                          input logic               clear_first);
    job_t j;
    int   gap;
    j.start_time = start_at;
    j.due_time   = end_at;
    j.first      = clear_first;
    if (!calm && !steady && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      job_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    job_if.valid <= 1'b1;
    job_if.data  <= j;
    @(posedge clk_i);
    while (!job_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Stops the sender and waits until every expected result word is back,
  // then lets the pipeline run out before anything else happens.
  task automatic settle_block();
    job_if.valid <= 1'b0;
    while (ledger.awaited.size() != 0) @(negedge clk_i);
    repeat (DRAIN_GAP) @(negedge clk_i);
  endtask

  // The room count is only written with the block empty, so the scoreboard
  // can take the new value at once.
  task automatic set_room_count(input logic [CFG_W-1:0] count);
    settle_block();
    cfg_wdata_i <= count;
    cfg_we_i    <= 1'b1;
    ledger.room_count = count;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One stretch of traffic. Most words are well formed: start times climb
  // by a random step and durations are random up to span, which keeps rooms
  // busy enough for both free placements and delays. A few words are stray
  // (random times, out of order, sometimes a mid-stream clear), end before
  // they start, or ask for the largest end time.
  task automatic offer_schedule(input int count, input bit fresh,
                                input int spacing, input int span);
    logic [STAMP_W-1:0] t;
    logic [STAMP_W-1:0] s;
    logic [STAMP_W-1:0] e;
    logic               f;
    int                 pick;
    t = ($urandom_range(0, 1) != 0) ? $urandom() : $urandom_range(0, 2000);
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      f = (k == 0) && fresh;
      s = t;
      e = t + $urandom_range(0, span);
      if (pick < 6) begin
        s = $urandom();
        e = $urandom();
        f = ($urandom_range(0, 7) == 0);
      end else if (pick < 11) begin
        e = t - $urandom_range(1, 40);
      end else if (pick < 14) begin
        e = '1;
      end
      send_job(s, e, f);
      if (pick >= 6) t = t + $urandom_range(0, spacing);
    end
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] phase_rooms [8];
    bit               phase_fresh [8];
    ledger = new();
    calm         = 1'b0;
    steady       = 1'b0;
    hold_request = 1'b0;
    cycles       = 0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    job_if.valid = 1'b0;
    job_if.data  = '0;
    // The two room counts past the legal range and the zero count are in the
    // list on purpose; the 2-room phase keeps the state of the 7-room phase.
    phase_rooms = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd7, 5'd2, 5'd6};
    phase_fresh = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part with three rooms.
    set_room_count(5'd3);
    send_job(32'd0, 32'd10, 1'b1);   // lowest free room
    send_job(32'd0, 32'd5, 1'b0);    // next room up
    send_job(32'd0, 32'd0, 1'b0);    // zero duration
    send_job(32'd1, 32'd0, 1'b0);    // end before start counts as zero
    send_job(32'd2, 32'd7, 1'b0);
    send_job(32'd3, 32'd13, 1'b0);   // all rooms busy, delayed into the earliest
    send_job(32'd4, 32'd6, 1'b0);
    send_job(32'd20, 32'd30, 1'b1);  // clear, then fill all rooms to the same time
    send_job(32'd20, 32'd30, 1'b0);
    send_job(32'd20, 32'd30, 1'b0);
    send_job(32'd21, 32'd22, 1'b0);  // equal free times go to the lowest room
    send_job(32'd31, 32'd31, 1'b0);  // free exactly at the start time
    send_job(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_job(32'hFFFF_FFFF, 32'd0, 1'b0);
    send_job(32'd0, 32'hFFFF_FFFF, 1'b1);
    send_job(32'd0, 32'hFFFF_FFFF, 1'b0);
    send_job(32'd0, 32'hFFFF_FFFF, 1'b0);
    send_job(32'd0, 32'hFFFF_FFFF, 1'b0);  // delay adds a full-width duration
    send_job(32'd5, 32'd3, 1'b0);
    send_job(32'd1, 32'd2, 1'b0);          // out of order start time

    // Random phases. Each room count change waits for the block to drain,
    // which is also the sender's pause until every result is back.
    for (int p = 0; p < 8; p++) begin
      set_room_count(phase_rooms[p]);
      if (p == 1) begin
        // Long result stall while the sender keeps pushing, so both pipeline
        // stages fill and job ready drops.
        hold_request = 1'b1;
        steady = 1'b1;
        offer_schedule(30, 1'b1, 4, 80);
        steady = 1'b0;
      end
      offer_schedule(22, phase_fresh[p], 6, 40 + 15 * p);
      offer_schedule(22, 1'b1, $urandom_range(0, 12), $urandom_range(1, 200));
    end

    // Last part without any idling on either side.
    calm = 1'b1;
    set_room_count(5'd4);
    offer_schedule(100, 1'b1, 5, 60);

    // One room and a chain of delayed full-width jobs stack their durations
    // onto its free time, well past the 32-bit range.
    set_room_count(5'd1);
    send_job(32'd0, 32'hFFFF_FFFF, 1'b1);
    for (int k = 0; k < DELAY_CHAIN; k++) send_job(32'd0, 32'hFFFF_FFFF, 1'b0);

    settle_block();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (ledger.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
